/* rtl/load_cell_reader_tare_scale_unit_assert.svh */
// Assertion macros for the load cell reader. They expand to nothing when
// SYNTHESIS is defined.
`ifndef LOAD_CELL_READER_TARE_SCALE_UNIT_ASSERT_SVH
`define LOAD_CELL_READER_TARE_SCALE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LCTSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("load cell reader: same-cycle check failed");
`define LCTSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("load cell reader: next-cycle check failed");
`else
`define LCTSU_ASSERT_NOW(label, ante, cons)
`define LCTSU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/lctsu_pkg.sv */
package lctsu_pkg;

  localparam int SampleBits = 24;
  localparam int PulseW     = $clog2(SampleBits);
  localparam int RawW       = 24;
  localparam int RefW       = 16;
  localparam int WtW        = 32;
  localparam int CoefW      = 48;
  localparam int FracBits   = 24;
  // Multiplier magnitude is at most RawW bits; one spare step keeps the
  // product aligned so that the fractional cut lands on the top sr bit.
  localparam int MulSteps   = RawW + 1;
  localparam int DivSteps   = CoefW;
  localparam int StepW      = $clog2(DivSteps);
  localparam int NumPad     = CoefW - (RefW + 1) - FracBits;

  // For x below 2^48, floor(x / 10) equals floor((x >> 1) * RecipFive / 2^50).
  // A full multiply leaves the product shifted down by 47 on product_q, so
  // TenShift more bits are dropped afterwards.
  localparam logic [CoefW-1:0] RecipFive = 48'hCCCC_CCCC_CCCD;
  localparam int TenSteps = CoefW;
  localparam int TenShift = 3;

  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpRead  = 3'd1;
  localparam logic [2:0] OpTare  = 3'd2;
  localparam logic [2:0] OpCal   = 3'd3;
  localparam logic [2:0] OpWeigh = 3'd4;

  localparam logic RegGainPulses = 1'b0;
  localparam logic RegHalfPeriod = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DHI,
    PH_DLO,
    PH_GHI,
    PH_GLO
  } ph_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_EVAL,
    S_MUL,
    S_LOAD10,
    S_DIV10,
    S_CDIV,
    S_FIX_W,
    S_FIX_C,
    S_DONE
  } blk_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    load;
    logic    step;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic                   finish;
    logic                   busy;
    logic                   clock_lvl;
    logic [2:0]             cmd;
    logic signed [RefW-1:0] ref_w;
    logic [RawW-1:0]        sample;
  } pin_stat_t;

  typedef struct packed {
    logic [2:0]             opcode;
    logic signed [RefW-1:0] ref_weight;
    logic                   data_in;
  } item_t;

  typedef struct packed {
    logic                    clock_out;
    logic                    busy_res;
    logic                    done_res;
    logic                    status;
    logic [RawW-1:0]         raw_sample;
    logic signed [WtW-1:0]   weight_centi;
    logic signed [CoefW-1:0] coefficient;
  } res_t;

endpackage

/* rtl/lctsu_alu.sv */
module lctsu_alu import lctsu_pkg::*; (
  input  logic             clk,
  input  alu_ctl_t         ctl,
  input  logic [CoefW-1:0] ld_sr,
  input  logic [CoefW-1:0] ld_opnd,
  output logic [CoefW-1:0] product_q,
  output logic [CoefW-1:0] quotient
);

  logic [CoefW-1:0] acc;
  logic [CoefW-1:0] sr;
  logic [CoefW-1:0] opnd;

  logic [CoefW-1:0] add_x;
  logic [CoefW-1:0] add_y;
  logic             cin;
  logic [CoefW:0]   sum;
  logic [RawW:0]    trial;
  logic             ge;

  // Shift-and-add multiply keeps the running high half in acc and shifts
  // product bits into the top of sr. Restoring divide keeps the remainder
  // in acc and shifts quotient bits into the bottom of sr.
  assign trial = {acc[RawW-1:0], sr[CoefW-1]};
  assign ge    = sum[CoefW];
  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{CoefW{1'b0}}, cin};

  always_comb begin
    unique case (ctl.op)
      ALU_MUL: begin
        add_x = acc;
        add_y = sr[0] ? opnd : '0;
        cin   = 1'b0;
      end
      ALU_DIV: begin
        add_x = {{(CoefW-RawW-1){1'b0}}, trial};
        add_y = ~opnd;
        cin   = 1'b1;
      end
      default: begin
        add_x = acc;
        add_y = '0;
        cin   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc  <= '0;
      sr   <= ld_sr;
      opnd <= ld_opnd;
    end else if (ctl.step) begin
      if (ctl.op == ALU_MUL) begin
        acc <= sum[CoefW:1];
        sr  <= {sum[0], sr[CoefW-1:1]};
      end else begin
        acc <= {{(CoefW-RawW){1'b0}}, (ge ? sum[RawW-1:0] : trial[RawW-1:0])};
        sr  <= {sr[CoefW-2:0], ge};
      end
    end
  end

  assign product_q = {acc[CoefW-2:0], sr[CoefW-1]};
  assign quotient  = sr;

endmodule

/* rtl/lctsu_pin.sv */
module lctsu_pin import lctsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  item_t      item_q,
  input  logic [1:0] gain_pulses,
  input  logic [7:0] half_period_ticks,
  output pin_stat_t  stat
);

  ph_t                    phase, phase_next;
  logic [7:0]             tick_count, tick_count_next;
  logic [PulseW-1:0]      pulse_count, pulse_count_next;
  logic [RawW-1:0]        shift_value, shift_value_next;
  logic [2:0]             pending_command, pending_command_next;
  logic signed [RefW-1:0] held_reference, held_reference_next;
  logic                   finish, finish_next;

  logic [7:0]        h;
  logic [1:0]        g;
  logic [8:0]        tick_inc;
  logic              tick_hit;
  logic [PulseW:0]   pulse_inc;
  logic              start_op;

  // A zero setting in either register behaves as one.
  assign h         = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign g         = (gain_pulses == 2'd0) ? 2'd1 : gain_pulses;
  assign tick_inc  = {1'b0, tick_count} + 9'd1;
  assign tick_hit  = tick_inc >= {1'b0, h};
  assign pulse_inc = {1'b0, pulse_count} + {{PulseW{1'b0}}, 1'b1};
  assign start_op  = (item_q.opcode == OpRead) || (item_q.opcode == OpTare) ||
                     (item_q.opcode == OpCal) || (item_q.opcode == OpWeigh);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      pulse_count     <= '0;
      shift_value     <= '0;
      pending_command <= OpTick;
      held_reference  <= '0;
      finish          <= 1'b0;
    end else if (tick) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      pulse_count     <= pulse_count_next;
      shift_value     <= shift_value_next;
      pending_command <= pending_command_next;
      held_reference  <= held_reference_next;
      finish          <= finish_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    pulse_count_next     = pulse_count;
    shift_value_next     = shift_value;
    pending_command_next = pending_command;
    held_reference_next  = held_reference;
    finish_next          = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_op) begin
          pending_command_next = item_q.opcode;
          held_reference_next  = item_q.ref_weight;
          phase_next           = PH_DHI;
          tick_count_next      = '0;
          pulse_count_next     = '0;
          shift_value_next     = '0;
        end
      end
      PH_DHI: begin
        tick_count_next = tick_inc[7:0];
        if (tick_hit) begin
          tick_count_next  = '0;
          shift_value_next = {shift_value[RawW-2:0], item_q.data_in};
          phase_next       = PH_DLO;
        end
      end
      PH_DLO: begin
        tick_count_next = tick_inc[7:0];
        if (tick_hit) begin
          tick_count_next = '0;
          if (pulse_inc >= (PulseW+1)'(SampleBits)) begin
            pulse_count_next = '0;
            phase_next       = PH_GHI;
          end else begin
            pulse_count_next = pulse_inc[PulseW-1:0];
            phase_next       = PH_DHI;
          end
        end
      end
      PH_GHI: begin
        tick_count_next = tick_inc[7:0];
        if (tick_hit) begin
          tick_count_next = '0;
          phase_next      = PH_GLO;
        end
      end
      PH_GLO: begin
        tick_count_next = tick_inc[7:0];
        if (tick_hit) begin
          tick_count_next = '0;
          if (pulse_inc >= {{(PulseW-1){1'b0}}, g}) begin
            pulse_count_next = '0;
            finish_next      = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            pulse_count_next = pulse_inc[PulseW-1:0];
            phase_next       = PH_GHI;
          end
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        tick_count_next  = '0;
        pulse_count_next = '0;
      end
    endcase
  end

  assign stat.finish    = finish;
  assign stat.busy      = phase != PH_IDLE;
  assign stat.clock_lvl = (phase == PH_DHI) || (phase == PH_GHI);
  assign stat.cmd       = pending_command;
  assign stat.ref_w     = held_reference;
  assign stat.sample    = shift_value;

endmodule

/* rtl/load_cell_reader_tare_scale_unit.sv */
// Channel   Direction  Handshake                   Beat carries
// item      in         item_valid / item_stall     opcode, ref_weight, data_in
// result    out        result_valid / result_stall clock_out ... coefficient
// apb       in         psel / penable / pready     gain_pulses, half_period_ticks
//
// Every item beat yields exactly one result beat, one item in flight at a time.
// An item that starts no arithmetic passes only through the tick, evaluate and
// done states; a finishing calibrate with a nonzero difference and a finishing
// weigh also use the shared shift/add unit: 48 divide steps for calibrate and 25
// multiply steps plus 48 reciprocal multiply steps for the divide by ten in weigh.
// Reset is synchronous; afterwards the block is idle and ready at once.
// A stalled result is held in its output register; the next item runs up to done.
module load_cell_reader_tare_scale_unit import lctsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output res_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] gain_pulses;
  logic [7:0] half_period_ticks;
  logic       cfg_wr;

  blk_t                    state, state_next;
  item_t                   item_q;
  logic [RawW-1:0]         zero_offset, zero_offset_next;
  logic signed [CoefW-1:0] scale_coef, scale_coef_next;
  logic                    neg, neg_next;
  logic                    done_q, done_next;
  logic                    status_q, status_next;
  logic [RawW-1:0]         raw_q, raw_next;
  logic [WtW-1:0]          wt_q, wt_next;
  logic [StepW-1:0]        cnt, cnt_next;
  logic                    result_load;

  pin_stat_t        stat;
  logic             tick;
  alu_ctl_t         alu_ctl;
  logic [CoefW-1:0] ld_sr;
  logic [CoefW-1:0] ld_opnd;
  logic [CoefW-1:0] product_q;
  logic [CoefW-1:0] quotient;

  logic [RawW:0]    diff;
  logic             diff_neg;
  logic [RawW:0]    diff_mag;
  logic [RefW:0]    ref_ext;
  logic [RefW:0]    ref_mag;
  logic             coef_neg;
  logic [CoefW-1:0] coef_mag;
  logic [CoefW-1:0] q10;
  logic [CoefW-1:0] q_sat;
  logic [CoefW-1:0] q_neg;
  logic [CoefW-1:0] coef_signed;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pulses       <= 2'd1;
      half_period_ticks <= 8'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == RegGainPulses) begin
        gain_pulses <= pwdata[1:0];
      end else begin
        half_period_ticks <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegGainPulses) ? {30'd0, gain_pulses}
                                              : {24'd0, half_period_ticks};

  lctsu_pin u_pin (
    .clk               (clk),
    .rst               (rst),
    .tick              (tick),
    .item_q            (item_q),
    .gain_pulses       (gain_pulses),
    .half_period_ticks (half_period_ticks),
    .stat              (stat)
  );

  lctsu_alu u_alu (
    .clk       (clk),
    .ctl       (alu_ctl),
    .ld_sr     (ld_sr),
    .ld_opnd   (ld_opnd),
    .product_q (product_q),
    .quotient  (quotient)
  );

  // Operand magnitudes and signs for the shared unit.
  assign diff     = {1'b0, stat.sample} - {1'b0, zero_offset};
  assign diff_neg = diff[RawW];
  assign diff_mag = diff_neg ? ((RawW+1)'(0) - diff) : diff;
  assign ref_ext  = {stat.ref_w[RefW-1], stat.ref_w};
  assign ref_mag  = stat.ref_w[RefW-1] ? ((RefW+1)'(0) - ref_ext) : ref_ext;
  assign coef_neg = scale_coef[CoefW-1];
  assign coef_mag = coef_neg ? (CoefW'(0) - scale_coef) : scale_coef;

  // Magnitude of the weight after the divide by ten.
  assign q10 = product_q >> TenShift;

  // The negative limit is one larger in magnitude than the positive one.
  assign q_sat       = (q10 > CoefW'(33'h0_8000_0000)) ? CoefW'(33'h0_8000_0000)
                                                        : q10;
  assign q_neg       = CoefW'(0) - q_sat;
  assign coef_signed = neg ? (CoefW'(0) - quotient) : quotient;

  assign item_stall  = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      zero_offset  <= '0;
      scale_coef   <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      zero_offset  <= zero_offset_next;
      scale_coef   <= scale_coef_next;
      cnt          <= cnt_next;
      result_valid <= result_load || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    neg      <= neg_next;
    done_q   <= done_next;
    status_q <= status_next;
    raw_q    <= raw_next;
    wt_q     <= wt_next;
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
    if (result_load) begin
      result.clock_out    <= stat.clock_lvl;
      result.busy_res     <= stat.busy;
      result.done_res     <= done_q;
      result.status       <= status_q;
      result.raw_sample   <= raw_q;
      result.weight_centi <= wt_q;
      result.coefficient  <= scale_coef;
    end
  end

  always_comb begin
    state_next       = state;
    zero_offset_next = zero_offset;
    scale_coef_next  = scale_coef;
    neg_next         = neg;
    done_next        = done_q;
    status_next      = status_q;
    raw_next         = raw_q;
    wt_next          = wt_q;
    cnt_next         = cnt;
    result_load      = 1'b0;
    tick             = 1'b0;
    alu_ctl          = '{load: 1'b0, step: 1'b0, op: ALU_MUL};
    ld_sr            = '0;
    ld_opnd          = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_TICK;
        end
      end
      S_TICK: begin
        tick       = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        done_next   = stat.finish;
        status_next = 1'b0;
        wt_next     = '0;
        raw_next    = stat.finish ? stat.sample : '0;
        cnt_next    = '0;
        state_next  = S_DONE;
        if (stat.finish) begin
          unique case (stat.cmd)
            OpTare: begin
              zero_offset_next = stat.sample;
            end
            OpCal: begin
              if (diff == '0) begin
                status_next = 1'b1;
              end else begin
                alu_ctl    = '{load: 1'b1, step: 1'b0, op: ALU_DIV};
                ld_sr      = {{NumPad{1'b0}}, ref_mag, {FracBits{1'b0}}};
                ld_opnd    = {{(CoefW-RawW){1'b0}}, diff_mag[RawW-1:0]};
                neg_next   = stat.ref_w[RefW-1] ^ diff_neg;
                state_next = S_CDIV;
              end
            end
            OpWeigh: begin
              alu_ctl    = '{load: 1'b1, step: 1'b0, op: ALU_MUL};
              ld_sr      = {{(CoefW-RawW){1'b0}}, diff_mag[RawW-1:0]};
              ld_opnd    = coef_mag;
              neg_next   = diff_neg ^ coef_neg;
              state_next = S_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        alu_ctl  = '{load: 1'b0, step: 1'b1, op: ALU_MUL};
        cnt_next = cnt + StepW'(1);
        if (cnt == StepW'(MulSteps - 1)) begin
          state_next = S_LOAD10;
        end
      end
      S_LOAD10: begin
        // The divide by ten is a multiply by the reciprocal of five on half
        // the scaled product.
        alu_ctl    = '{load: 1'b1, step: 1'b0, op: ALU_MUL};
        ld_sr      = {1'b0, product_q[CoefW-1:1]};
        ld_opnd    = RecipFive;
        cnt_next   = '0;
        state_next = S_DIV10;
      end
      S_DIV10: begin
        alu_ctl  = '{load: 1'b0, step: 1'b1, op: ALU_MUL};
        cnt_next = cnt + StepW'(1);
        if (cnt == StepW'(TenSteps - 1)) begin
          state_next = S_FIX_W;
        end
      end
      S_CDIV: begin
        alu_ctl  = '{load: 1'b0, step: 1'b1, op: ALU_DIV};
        cnt_next = cnt + StepW'(1);
        if (cnt == StepW'(DivSteps - 1)) begin
          state_next = S_FIX_C;
        end
      end
      S_FIX_W: begin
        if (neg) begin
          wt_next = q_neg[WtW-1:0];
        end else if (q10 > CoefW'(32'h7FFF_FFFF)) begin
          wt_next = 32'h7FFF_FFFF;
        end else begin
          wt_next = q10[WtW-1:0];
        end
        state_next = S_DONE;
      end
      S_FIX_C: begin
        scale_coef_next = coef_signed;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`include "load_cell_reader_tare_scale_unit_assert.svh"

  `LCTSU_ASSERT_NEXT(a_accept_ticks, item_valid && !item_stall, state == S_TICK)
  `LCTSU_ASSERT_NOW(a_alu_step_state, alu_ctl.step, state == S_MUL || state == S_DIV10 || state == S_CDIV)
  `LCTSU_ASSERT_NOW(a_done_not_busy, result_valid && result.done_res, !result.busy_res)
  `LCTSU_ASSERT_NOW(a_status_on_done, result_valid && result.status, result.done_res)
  `LCTSU_ASSERT_NOW(a_weight_on_done, result_valid && (result.weight_centi != 32'sd0), result.done_res)

endmodule

/* tb/load_cell_reader_tare_scale_unit_tb.sv */
`timescale 1ns / 1ps

module load_cell_reader_tare_scale_unit_tb import lctsu_pkg::*; ();

  localparam logic [2:0] GainAddr = {RegGainPulses, 2'b00};
  localparam logic [2:0] HalfAddr = {RegHalfPeriod, 2'b00};
  localparam int QuietLimit = 1000;
  localparam int ItemTarget = 1650;

  // Tracks the reader's pin sequencer, tare point and scale coefficient, and
  // holds the result beats it expects, oldest first.
  class scale_tracker;
    logic [1:0]  gain;
    logic [7:0]  half;
    ph_t         phase;
    logic [7:0]  ticks;
    logic [4:0]  pulses;
    logic [23:0] shifted;
    logic [23:0] zero;
    logic [47:0] coef;
    logic [2:0]  cmd;
    logic [15:0] held_ref;
    res_t        pending_results[$];
    int          fails;

    function new();
      gain = 2'd1;
      half = 8'd1;
      phase = PH_IDLE;
      ticks = '0;
      pulses = '0;
      shifted = '0;
      zero = '0;
      coef = '0;
      cmd = OpTick;
      held_ref = '0;
      fails = 0;
    endfunction

    function int half_ticks();
      return (half == 0) ? 1 : int'(half);
    endfunction

    function int gain_count();
      return (gain == 0) ? 1 : int'(gain);
    endfunction

    // The data pin is taken on the last tick of each data high phase.
    function bit sampling_tick();
      return phase == PH_DHI && int'(ticks) + 1 >= half_ticks();
    endfunction

    function void report(string msg);
      $display("load cell check: %s", msg);
      fails++;
    endfunction

    // trunc(diff * coef / 2^24 / 10), clamped to 32 bits
    function logic [31:0] scaled_weight(logic signed [63:0] diff, logic signed [63:0] c);
      logic neg;
      logic [63:0] a, b, q;
      neg = (diff < 0) != (c < 0);
      a = (diff < 0) ? -diff : diff;
      b = (c < 0) ? -c : c;
      q = a * (b >> 24) + ((a * (b & 64'hFF_FFFF)) >> 24);
      q = q / 10;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        q = 64'd0 - q;
      end else if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
      end
      return q[31:0];
    endfunction

    function void note_tick(item_t it);
      res_t r;
      bit fin;
      logic signed [63:0] diff, num, quot;
      r = '0;
      fin = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (it.opcode >= OpRead && it.opcode <= OpWeigh) begin
            cmd = it.opcode;
            held_ref = it.ref_weight;
            phase = PH_DHI;
            ticks = '0;
            pulses = '0;
            shifted = '0;
          end
        end
        PH_DHI: begin
          ticks++;
          if (int'(ticks) >= half_ticks()) begin
            ticks = '0;
            shifted = {shifted[22:0], it.data_in};
            phase = PH_DLO;
          end
        end
        PH_DLO: begin
          ticks++;
          if (int'(ticks) >= half_ticks()) begin
            ticks = '0;
            if (int'(pulses) + 1 >= SampleBits) begin
              pulses = '0;
              phase = PH_GHI;
            end else begin
              pulses++;
              phase = PH_DHI;
            end
          end
        end
        PH_GHI: begin
          ticks++;
          if (int'(ticks) >= half_ticks()) begin
            ticks = '0;
            phase = PH_GLO;
          end
        end
        PH_GLO: begin
          ticks++;
          if (int'(ticks) >= half_ticks()) begin
            ticks = '0;
            if (int'(pulses) + 1 >= gain_count()) begin
              pulses = '0;
              fin = 1'b1;
            end else begin
              pulses++;
              phase = PH_GHI;
            end
          end
        end
        default: begin
          phase = PH_IDLE;
          ticks = '0;
          pulses = '0;
        end
      endcase

      if (fin) begin
        diff = $signed({40'd0, shifted}) - $signed({40'd0, zero});
        phase = PH_IDLE;
        r.done_res = 1'b1;
        r.raw_sample = shifted;
        case (cmd)
          OpTare: zero = shifted;
          OpCal: begin
            // A zero span cannot be calibrated; the old coefficient stays.
            if (diff == 0) begin
              r.status = 1'b1;
            end else begin
              num = $signed(held_ref) * 64'sd16777216;
              quot = num / diff;
              coef = quot[47:0];
            end
          end
          OpWeigh: r.weight_centi = scaled_weight(diff, $signed({{16{coef[47]}}, coef}));
          default: ;
        endcase
      end

      r.clock_out = (phase == PH_DHI || phase == PH_GHI);
      r.busy_res = (phase != PH_IDLE);
      r.coefficient = coef;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    function void check_result(res_t r);
      res_t e;
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending_results.pop_front();
      cmp_field("clock_out", r.clock_out, e.clock_out);
      cmp_field("busy_res", r.busy_res, e.busy_res);
      cmp_field("done_res", r.done_res, e.done_res);
      cmp_field("status", r.status, e.status);
      cmp_field("raw_sample", r.raw_sample, e.raw_sample);
      cmp_field("weight_centi", r.weight_centi, e.weight_centi);
      cmp_field("coefficient", r.coefficient, e.coefficient);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  res_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scale_tracker tracker;
  bit idle_on = 1'b1;
  int sent = 0;
  int quiet = 0;
  int stall_cycles;

  load_cell_reader_tare_scale_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) tracker.note_tick(item);
      if (result_valid && !result_stall) tracker.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("load_cell_reader_tare_scale_unit_tb: errors");
        $finish;
      end
    end
  end

  // Result side: hold stall for a random number of cycles, then take one beat.
  initial begin
    @(negedge clk);
    forever begin
      stall_cycles = idle_on ? $urandom_range(0, 6) : 0;
      if (stall_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  // Valid stays high on return, so a caller that pauses drops it first.
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result beat has arrived.
  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
  endtask

  // Writes a register, then reads it back.
  task automatic reg_set(input logic [2:0] addr, input logic [31:0] val);
    logic [31:0] mask;
    mask = (addr == GainAddr) ? 32'h3 : 32'hFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == GainAddr) tracker.gain = val[1:0];
    else tracker.half = val[7:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (val & mask))
      tracker.report($sformatf("register %0d read %0h expected %0h", addr, prdata & mask,
                               val & mask));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] g, input logic [7:0] h);
    drain();
    reg_set(GainAddr, {30'd0, g});
    reg_set(HalfAddr, {24'd0, h});
  endtask

  // Ticks while idle that start nothing: opcode zero or one of the unused codes.
  task automatic idle_ticks(input int n);
    item_t it;
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 3);
      it.opcode = (sel == 0) ? OpTick : OpWeigh + 3'(sel);
      it.ref_weight = 16'($urandom);
      it.data_in = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  // Starts a command and clocks it to the end, presenting the bits of the
  // chosen sample on the sampling ticks and noise everywhere else.
  task automatic run_cmd(input logic [2:0] op, input logic [15:0] refw,
                         input logic [23:0] sample);
    item_t it;
    it.opcode = op;
    it.ref_weight = refw;
    it.data_in = 1'($urandom_range(0, 1));
    send_item(it);
    while (tracker.phase != PH_IDLE) begin
      it.opcode = 3'($urandom_range(0, 7));
      it.ref_weight = 16'($urandom);
      it.data_in = tracker.sampling_tick() ? sample[RawW - 1 - tracker.pulses]
                                            : 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  function automatic logic [23:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return 24'h00_0000;
      1: return 24'hFF_FFFF;
      2: return tracker.zero;
      3: return tracker.zero + 24'd1;
      4: return tracker.zero - 24'd1;
      5: return tracker.zero + 24'($urandom_range(0, 64)) - 24'd32;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_ref();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    tracker = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero settings act as one, extremes of the sample, tare,
    // calibration with no span, largest coefficients, clamped weights.
    configure(2'd0, 8'd0);
    run_cmd(OpRead, 16'h7FFF, 24'hFF_FFFF);
    idle_ticks(4);
    run_cmd(OpRead, 16'h8000, 24'h00_0000);
    run_cmd(OpWeigh, 16'h0000, 24'h12_3456);
    run_cmd(OpTare, 16'h0000, 24'h80_0000);
    run_cmd(OpCal, 16'd100, 24'h80_0000);
    run_cmd(OpCal, 16'h7FFF, 24'h80_0001);
    run_cmd(OpWeigh, 16'h0000, 24'hFF_FFFF);
    run_cmd(OpWeigh, 16'h0000, 24'h00_0000);
    configure(2'd3, 8'd2);
    run_cmd(OpCal, 16'h8000, 24'h80_0001);
    run_cmd(OpWeigh, 16'h0000, 24'hFF_FFFF);
    run_cmd(OpCal, 16'd7, 24'h7F_FFFD);
    run_cmd(OpWeigh, 16'h0000, 24'h80_0123);
    configure(2'd2, 8'd1);
    run_cmd(OpCal, 16'd12345, 24'h00_0000);
    run_cmd(OpWeigh, 16'h0000, 24'h7F_FF00);

    while (sent < ItemTarget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0)
        configure(2'($urandom_range(0, 3)),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom_range(3, 6))
                                              : 8'($urandom_range(0, 2)));
      else if ($urandom_range(0, 9) == 0)
        drain();
      idle_ticks($urandom_range(0, 3));
      run_cmd(3'($urandom_range(OpRead, OpWeigh)), pick_ref(), pick_raw());
    end

    drain();
    repeat (100) @(negedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.report($sformatf("%0d result beats never arrived",
                               tracker.pending_results.size()));
    if (tracker.fails == 0) begin
      $display("load_cell_reader_tare_scale_unit_tb: clean");
    end else begin
      $display("load_cell_reader_tare_scale_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lctsu_pkg.sv
rtl/lctsu_alu.sv
rtl/lctsu_pin.sv
rtl/load_cell_reader_tare_scale_unit.sv
tb/load_cell_reader_tare_scale_unit_tb.sv
